/* src/vertex_dedup_indexer_unit_macros.svh */
// Assertion macros for the vertex dedup indexer.
`ifndef VERTEX_DEDUP_INDEXER_UNIT_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock edge outside reset.
`define VDI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex dedup indexer: assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex dedup indexer: assertion failed");

`else

`define VDI_ASSERT_NOW(label, clk, rst, ante, cons)
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/vdi_pkg.sv */
// Types and constants shared by the vertex dedup indexer modules.
package vdi_pkg;

   localparam int WORD_W              = 32;
   localparam int INDEX_W             = 8;
   localparam int DEFAULT_TABLE_DEPTH = 256;

   typedef logic [WORD_W-1:0] vdi_word_type;

   // One vertex as stored and compared: eight raw float bit patterns.
   typedef struct packed {
      vdi_word_type pos_x;
      vdi_word_type pos_y;
      vdi_word_type pos_z;
      vdi_word_type norm_x;
      vdi_word_type norm_y;
      vdi_word_type norm_z;
      vdi_word_type tex_u;
      vdi_word_type tex_v;
   } vdi_vertex_type;

   typedef struct packed {
      logic         start_of_mesh;
      vdi_word_type pos_x;
      vdi_word_type pos_y;
      vdi_word_type pos_z;
      vdi_word_type norm_x;
      vdi_word_type norm_y;
      vdi_word_type norm_z;
      vdi_word_type tex_u;
      vdi_word_type tex_v;
   } vdi_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] vertex_index;
      logic               is_new;
      logic               overflow;
   } vdi_rsp_type;

endpackage

/* src/vdi_match_array.sv */
// Vertex table cells with one bitwise comparator per cell.
module vdi_match_array
   import vdi_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                   clock,
   input  vdi_vertex_type         lookup_vertex,
   input  logic [CNT_W-1:0]       lookup_count,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_slot,
   input  vdi_vertex_type         wr_vertex,
   output logic [TABLE_DEPTH-1:0] match_vec
);

   vdi_vertex_type cell_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_ff[wr_slot] <= wr_vertex;
      end
   end

   // Only cells below the live count take part; the rest are stale or unwritten.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_vec[i] = (CNT_W'(i) < lookup_count) && (cell_ff[i] == lookup_vertex);
      end
   end

endmodule

/* src/vertex_dedup_indexer_unit.sv */
// Top level of the vertex dedup indexer: input stage, match stage, result stage.
//
//   channel | ports                     | handshake
//   --------+---------------------------+-----------------------------------------
//   request | start, busy, req_data     | beat taken when start & !busy
//   result  | rsp_strobe, rsp_data      | one-cycle beat, receiver cannot stall
//
// One vertex per cycle, every cycle; busy is tied low.
// A taken beat passes the stage 1, stage 2 and result registers before it shows on rsp_strobe.
// Stage 1 compares against every table cell at once; stage 2 encodes the hit,
// allocates a slot and writes it. A bypass from stage 2 into stage 1 covers a
// vertex that is being stored while its duplicate is still in compare.
// Synchronous reset clears the fill count and valid flags; table cells hold
// junk until written and are never compared above the fill count.
`include "vertex_dedup_indexer_unit_macros.svh"

module vertex_dedup_indexer_unit
   import vdi_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  vdi_req_type req_data,
   output logic        rsp_strobe,
   output vdi_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // stage 1: input register
   logic                   stg1_valid_ff;
   logic                   stg1_start_ff;
   vdi_vertex_type         stg1_vertex_ff;

   // stage 2: match vector and vertex
   logic                   stg2_valid_ff;
   logic                   stg2_start_ff;
   vdi_vertex_type         stg2_vertex_ff;
   logic [TABLE_DEPTH-1:0] match_ff;
   logic [TABLE_DEPTH-1:0] match_in;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W-1:0]       count_base;
   logic [CNT_W-1:0]       lookup_count;

   logic [TABLE_DEPTH-1:0] array_match;
   logic [IDX_W-1:0]       hit_slot;
   logic [IDX_W-1:0]       new_slot;
   logic [31:0]            slot_ext;
   logic                   hit2;
   logic                   full2;
   logic                   store2;
   logic                   bypass_hit;

   logic                   rsp_strobe_ff;
   vdi_rsp_type            rsp_ff;
   vdi_rsp_type            rsp_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg1_valid_ff <= 1'b0;
      end else begin
         stg1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      stg1_start_ff  <= req_data.start_of_mesh;
      stg1_vertex_ff <= '{pos_x:  req_data.pos_x,  pos_y:  req_data.pos_y,
                          pos_z:  req_data.pos_z,  norm_x: req_data.norm_x,
                          norm_y: req_data.norm_y, norm_z: req_data.norm_z,
                          tex_u:  req_data.tex_u,  tex_v:  req_data.tex_v};
   end

   // Fill count as seen after the stage 2 beat's mesh restart.
   assign count_base = (stg2_valid_ff && stg2_start_ff) ? '0 : count_ff;
   assign hit2       = |match_ff;
   assign full2      = count_base >= CNT_W'(TABLE_DEPTH);
   assign store2     = stg2_valid_ff && !hit2 && !full2;
   assign new_slot   = count_base[IDX_W-1:0];

   // A new mesh in stage 1 sees an empty table.
   assign lookup_count = stg1_start_ff ? '0 : count_base;

   vdi_match_array #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_match_array (
      .clock         (clock),
      .lookup_vertex (stg1_vertex_ff),
      .lookup_count  (lookup_count),
      .wr_en         (store2),
      .wr_slot       (new_slot),
      .wr_vertex     (stg2_vertex_ff),
      .match_vec     (array_match)
   );

   // The slot written this cycle is not in the cells yet: compare directly.
   assign bypass_hit = store2 && !stg1_start_ff && (stg1_vertex_ff == stg2_vertex_ff);

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_in[i] = array_match[i] || (bypass_hit && (CNT_W'(i) == count_base));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg2_valid_ff <= 1'b0;
      end else begin
         stg2_valid_ff <= stg1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      stg2_start_ff  <= stg1_start_ff;
      stg2_vertex_ff <= stg1_vertex_ff;
      match_ff       <= match_in;
   end

   // Stored vertices are unique, so at most one bit is set: OR the indices.
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (match_ff[i]) begin
            hit_slot = hit_slot | IDX_W'(i);
         end
      end
   end

   always_comb begin
      rsp_in   = '0;
      slot_ext = 32'(hit2 ? hit_slot : new_slot);
      if (hit2) begin
         rsp_in.vertex_index = slot_ext[INDEX_W-1:0];
      end else if (full2) begin
         rsp_in.overflow = 1'b1;
      end else begin
         rsp_in.vertex_index = slot_ext[INDEX_W-1:0];
         rsp_in.is_new       = 1'b1;
      end
   end

   assign count_in = count_base + CNT_W'(store2);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (stg2_valid_ff) begin
            count_ff <= count_in;
         end
         rsp_strobe_ff <= stg2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `VDI_ASSERT_NOW(a_match_unique, clock, reset, stg2_valid_ff, $onehot0(match_ff))
   `VDI_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `VDI_ASSERT_NEXT(a_store_grows, clock, reset, store2, count_ff == $past(count_base) + CNT_W'(1))
   `VDI_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_strobe_ff, !(rsp_ff.is_new && rsp_ff.overflow))
   `VDI_ASSERT_NEXT(a_overflow_when_full, clock, reset, stg2_valid_ff && !hit2 && full2, rsp_ff.overflow)

endmodule
